// File: rtl/core/fnrs_pkg.sv
// Shared types and constants for the font name record selector.
// Depends on nothing; every other file in rtl/core imports it.
package fnrs_pkg;

    // Default configuration
    localparam int POSITION_BITS_DEF = 20;
    localparam int QUEUE_DEPTH_DEF   = 4;

    // Table layout and match keys
    localparam logic [15:0] LANG_EN_US    = 16'h0409;
    localparam logic [15:0] PLATFORM_MS   = 16'd3;
    localparam logic [15:0] REC_ID_FULL   = 16'd4;
    localparam logic [15:0] REC_ID_FAMILY = 16'd1;
    localparam logic [15:0] REC_ID_STYLE  = 16'd2;
    localparam logic [15:0] ENCODING_MAX  = 16'd1;
    localparam int          HEADER_BYTES  = 6;
    localparam int          RECORD_BYTES  = 12;

    // Result status codes
    typedef enum logic [2:0] {
        ST_FULL      = 3'd0,
        ST_PAIR      = 3'd1,
        ST_SHORT     = 3'd2,
        ST_FORMAT    = 3'd3,
        ST_OFFSET    = 3'd4,
        ST_TRUNC     = 3'd5,
        ST_NOT_FOUND = 3'd6,
        ST_RANGE     = 3'd7
    } status_t;

    // Which name a record supplies
    typedef enum logic [1:0] {
        NAME_FULL   = 2'd0,
        NAME_FAMILY = 2'd1,
        NAME_STYLE  = 2'd2
    } name_kind_t;

    // Outcome of one name lookup
    typedef enum logic [1:0] {
        LK_OK    = 2'd0,
        LK_NONE  = 2'd1,
        LK_RANGE = 2'd2
    } lk_code_t;

    typedef struct packed {
        lk_code_t    code;
        logic [15:0] offset;
        logic [14:0] length;
    } lk_t;

    // Input byte transfer
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_t;

    // Result transfer
    typedef struct packed {
        status_t     status;
        logic [15:0] first_offset;
        logic [14:0] first_length;
        logic [15:0] second_offset;
        logic [14:0] second_length;
    } out_t;

    // Command from front to back: a matching record, a table end, or both
    typedef struct packed {
        logic        rec_valid;
        name_kind_t  rec_kind;
        logic        rec_en;
        logic [15:0] rec_offset;
        logic [15:0] rec_length;
        logic        end_valid;
        logic        end_ok;
        status_t     end_status;
        logic [16:0] end_slen;
    } cmd_t;

endpackage

// File: rtl/core/font_name_record_selector_top.sv
// Top level of the font name record selector: front end, command queue, back end.
// Depends on fnrs_pkg, fnrs_front, fnrs_queue and fnrs_back.
// Throughput: one table byte per cycle; the back end stops popping while it resolves each table end,
//   a pause absorbed by the QUEUE_DEPTH-entry command queue, so input stalls only when it fills.
// Result path: a table end goes through the command queue, evaluation slot and output register.
// Reset: rst_n clears position, header, counters, slot valid bits and all handshake state.
module font_name_record_selector_top #(
    parameter int POSITION_BITS = fnrs_pkg::POSITION_BITS_DEF,
    parameter int QUEUE_DEPTH   = fnrs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           byte_valid,
    output logic           byte_ready,
    input  fnrs_pkg::in_t  byte_data,
    output logic           result_valid,
    input  logic           result_ready,
    output fnrs_pkg::out_t result
);
    import fnrs_pkg::*;

    logic push;
    logic pop;
    logic empty;
    logic full;
    cmd_t push_cmd;
    cmd_t head_cmd;

    fnrs_front #(
        .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_valid(byte_valid),
        .byte_ready(byte_ready),
        .byte_data (byte_data),
        .full      (full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    fnrs_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_cmd(push_cmd),
        .pop     (pop),
        .head_cmd(head_cmd),
        .empty   (empty),
        .full    (full)
    );

    fnrs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_cmd    (head_cmd),
        .empty       (empty),
        .pop         (pop),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

endmodule

// File: rtl/core/fnrs_front.sv
// Front end: takes table bytes, assembles header and name records, classifies them.
// Emits commands into the queue. Depends on fnrs_pkg.
module fnrs_front #(
    parameter int POSITION_BITS = fnrs_pkg::POSITION_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           byte_valid,
    output logic           byte_ready,
    input  fnrs_pkg::in_t  byte_data,
    input  logic           full,
    output logic           push,
    output fnrs_pkg::cmd_t push_cmd
);
    import fnrs_pkg::*;

    localparam int DLEN_W = POSITION_BITS + 1;

    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [15:0]              fmt_reg, fmt_next;
    logic [15:0]              cnt_reg, cnt_next;
    logic [15:0]              start_reg, start_next;
    logic [19:0]              expect_reg, expect_next;
    logic [3:0]               rec_k_reg, rec_k_next;
    logic [15:0]              rec_num_reg, rec_num_next;
    logic [7:0]               rec_bytes_reg [0:RECORD_BYTES-2];

    logic                     accept;
    logic                     in_rec;
    logic                     rec_done;
    logic [15:0]              plat, enc, lang, nid, rlen, roff;
    logic                     rec_match;
    name_kind_t               rec_kind;
    logic [15:0]              start_final;
    logic [DLEN_W-1:0]        dlen;
    logic [DLEN_W-1:0]        slen_full;
    status_t                  end_status;
    logic                     end_ok;
    logic [16:0]              slen_clamped;

    assign byte_ready = !full;
    assign accept     = byte_valid && byte_ready;
    assign in_rec     = (pos_reg >= POSITION_BITS'(HEADER_BYTES)) && (rec_num_reg < cnt_reg);
    assign rec_done   = in_rec && (rec_k_reg == 4'(RECORD_BYTES - 1));

    // Record field view; last byte of the offset comes straight from the input
    assign plat = {rec_bytes_reg[0], rec_bytes_reg[1]};
    assign enc  = {rec_bytes_reg[2], rec_bytes_reg[3]};
    assign lang = {rec_bytes_reg[4], rec_bytes_reg[5]};
    assign nid  = {rec_bytes_reg[6], rec_bytes_reg[7]};
    assign rlen = {rec_bytes_reg[8], rec_bytes_reg[9]};
    assign roff = {rec_bytes_reg[10], byte_data.data_byte};

    // Classify a completed record
    always_comb
    begin
        rec_match = (plat == PLATFORM_MS) && (enc <= ENCODING_MAX);
        rec_kind  = NAME_FULL;
        priority if (nid == REC_ID_FULL)
        begin
            rec_kind = NAME_FULL;
        end
        else if (nid == REC_ID_FAMILY)
        begin
            rec_kind = NAME_FAMILY;
        end
        else if (nid == REC_ID_STYLE)
        begin
            rec_kind = NAME_STYLE;
        end
        else
        begin
            rec_match = 1'b0;
        end
    end

    // Header checks at the end of a table, in priority order
    always_comb
    begin
        start_final = (pos_reg == POSITION_BITS'(HEADER_BYTES - 1))
                    ? {start_reg[7:0], byte_data.data_byte} : start_reg;
        dlen        = DLEN_W'(pos_reg) + DLEN_W'(1);
        slen_full   = dlen - DLEN_W'(start_final);
        end_ok      = 1'b0;
        end_status  = ST_SHORT;
        priority if (pos_reg < POSITION_BITS'(HEADER_BYTES - 1))
        begin
            end_status = ST_SHORT;
        end
        else if (fmt_reg != 16'd0)
        begin
            end_status = ST_FORMAT;
        end
        else if (20'(start_final) != expect_reg)
        begin
            end_status = ST_OFFSET;
        end
        else if (dlen < DLEN_W'(start_final))
        begin
            end_status = ST_TRUNC;
        end
        else
        begin
            end_ok     = 1'b1;
            end_status = ST_FULL;
        end
        // Anything past 17 bits already covers every offset plus length
        if (|slen_full[DLEN_W-1:17])
        begin
            slen_clamped = '1;
        end
        else
        begin
            slen_clamped = slen_full[16:0];
        end
    end

    // Command build
    always_comb
    begin
        push_cmd.rec_valid  = rec_done && rec_match;
        push_cmd.rec_kind   = rec_kind;
        push_cmd.rec_en     = (lang == LANG_EN_US);
        push_cmd.rec_offset = roff;
        push_cmd.rec_length = rlen;
        push_cmd.end_valid  = byte_data.last_byte;
        push_cmd.end_ok     = end_ok;
        push_cmd.end_status = end_status;
        push_cmd.end_slen   = slen_clamped;
        push = accept && (push_cmd.rec_valid || push_cmd.end_valid);
    end

    // Position, header and record counters
    always_comb
    begin
        pos_next     = pos_reg;
        fmt_next     = fmt_reg;
        cnt_next     = cnt_reg;
        start_next   = start_reg;
        expect_next  = expect_reg;
        rec_k_next   = rec_k_reg;
        rec_num_next = rec_num_reg;
        if (accept)
        begin
            if (pos_reg != '1)
            begin
                pos_next = pos_reg + POSITION_BITS'(1);
            end
            priority if (pos_reg < POSITION_BITS'(2))
            begin
                fmt_next = {fmt_reg[7:0], byte_data.data_byte};
            end
            else if (pos_reg < POSITION_BITS'(4))
            begin
                cnt_next = {cnt_reg[7:0], byte_data.data_byte};
            end
            else if (pos_reg < POSITION_BITS'(HEADER_BYTES))
            begin
                start_next = {start_reg[7:0], byte_data.data_byte};
            end
            else if (in_rec)
            begin
                if (rec_done)
                begin
                    rec_k_next   = 4'd0;
                    rec_num_next = rec_num_reg + 16'd1;
                end
                else
                begin
                    rec_k_next = rec_k_reg + 4'd1;
                end
            end
            // Record count is final once byte 4 arrives
            if (pos_reg == POSITION_BITS'(4))
            begin
                expect_next = 20'(HEADER_BYTES) + {1'b0, cnt_reg, 3'b000}
                            + {2'b00, cnt_reg, 2'b00};
            end
            if (byte_data.last_byte)
            begin
                pos_next     = '0;
                fmt_next     = '0;
                cnt_next     = '0;
                start_next   = '0;
                expect_next  = '0;
                rec_k_next   = '0;
                rec_num_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            fmt_reg     <= '0;
            cnt_reg     <= '0;
            start_reg   <= '0;
            expect_reg  <= '0;
            rec_k_reg   <= '0;
            rec_num_reg <= '0;
        end
        else
        begin
            pos_reg     <= pos_next;
            fmt_reg     <= fmt_next;
            cnt_reg     <= cnt_next;
            start_reg   <= start_next;
            expect_reg  <= expect_next;
            rec_k_reg   <= rec_k_next;
            rec_num_reg <= rec_num_next;
        end
    end

    // Record byte capture
    always_ff @(posedge clk)
    begin
        if (accept && in_rec && !rec_done)
        begin
            rec_bytes_reg[rec_k_reg] <= byte_data.data_byte;
        end
    end

    a_rec_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        rec_k_reg <= 4'(RECORD_BYTES - 1))
        else $error("record byte counter beyond record size");

endmodule

// File: rtl/core/fnrs_queue.sv
// Short command queue between front and back ends.
// Flip-flop storage with wrap-around pointers. Depends on fnrs_pkg.
module fnrs_queue #(
    parameter int DEPTH = fnrs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  fnrs_pkg::cmd_t push_cmd,
    input  logic           pop,
    output fnrs_pkg::cmd_t head_cmd,
    output logic           empty,
    output logic           full
);
    import fnrs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign empty    = (count_reg == CNT_W'(0));
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign head_cmd = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("command pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("command popped from an empty queue");

endmodule

// File: rtl/core/fnrs_back.sv
// Back end: keeps the first matching record per name slot and resolves the result.
// Pops commands from the queue and drives the output register. Depends on fnrs_pkg.
module fnrs_back (
    input  logic           clk,
    input  logic           rst_n,
    input  fnrs_pkg::cmd_t head_cmd,
    input  logic           empty,
    output logic           pop,
    output logic           result_valid,
    input  logic           result_ready,
    output fnrs_pkg::out_t result
);
    import fnrs_pkg::*;

    // Slot layout: two per name, English first
    localparam logic [2:0] SLOT_FULL_EN   = 3'd0;
    localparam logic [2:0] SLOT_FULL_ANY  = 3'd1;
    localparam logic [2:0] SLOT_FAM_EN    = 3'd2;
    localparam logic [2:0] SLOT_FAM_ANY   = 3'd3;
    localparam logic [2:0] SLOT_STYLE_EN  = 3'd4;
    localparam logic [2:0] SLOT_STYLE_ANY = 3'd5;
    localparam int         SLOTS          = 6;

    logic [SLOTS-1:0] seen_reg, seen_next;
    logic [15:0]      off_reg [0:SLOTS-1];
    logic [15:0]      len_reg [0:SLOTS-1];

    logic             eval_valid_reg, eval_valid_next;
    logic             end_ok_reg;
    status_t          end_status_reg;
    logic [16:0]      slen_reg;

    logic             out_valid_reg, out_valid_next;
    out_t             out_reg, out_next;

    logic             fire;
    logic [2:0]       en_slot, any_slot;
    logic             keep_en, keep_any;
    lk_t              lk_full, lk_fam, lk_style, lk_fail;

    // Pick English if present, else any language; then bounds check
    function automatic lk_t lookup(input logic seen_a, input logic seen_b,
                                   input logic [15:0] off_a, input logic [15:0] len_a,
                                   input logic [15:0] off_b, input logic [15:0] len_b,
                                   input logic [16:0] slen);
        lk_t         r;
        logic [15:0] off;
        logic [15:0] len;
        logic [16:0] sum;
        off = seen_a ? off_a : off_b;
        len = seen_a ? len_a : len_b;
        sum = {1'b0, off} + {1'b0, len};
        r.offset = off;
        r.length = len[15:1];
        if (!seen_a && !seen_b)
        begin
            r.code = LK_NONE;
        end
        else if (sum > slen)
        begin
            r.code = LK_RANGE;
        end
        else
        begin
            r.code = LK_OK;
        end
        return r;
    endfunction

    assign pop      = !empty && !eval_valid_reg;
    assign fire     = eval_valid_reg && (!out_valid_reg || result_ready);
    assign en_slot  = {head_cmd.rec_kind, 1'b0};
    assign any_slot = {head_cmd.rec_kind, 1'b1};
    assign keep_en  = pop && head_cmd.rec_valid && head_cmd.rec_en && !seen_reg[en_slot];
    assign keep_any = pop && head_cmd.rec_valid && !seen_reg[any_slot];

    // Slot valid bits: set on first keep, cleared when a table resolves
    always_comb
    begin
        seen_next = seen_reg;
        if (keep_en)
        begin
            seen_next[en_slot] = 1'b1;
        end
        if (keep_any)
        begin
            seen_next[any_slot] = 1'b1;
        end
        if (fire)
        begin
            seen_next = '0;
        end
    end

    // Result resolution
    always_comb
    begin
        lk_full  = lookup(seen_reg[SLOT_FULL_EN], seen_reg[SLOT_FULL_ANY],
                          off_reg[SLOT_FULL_EN], len_reg[SLOT_FULL_EN],
                          off_reg[SLOT_FULL_ANY], len_reg[SLOT_FULL_ANY], slen_reg);
        lk_fam   = lookup(seen_reg[SLOT_FAM_EN], seen_reg[SLOT_FAM_ANY],
                          off_reg[SLOT_FAM_EN], len_reg[SLOT_FAM_EN],
                          off_reg[SLOT_FAM_ANY], len_reg[SLOT_FAM_ANY], slen_reg);
        lk_style = lookup(seen_reg[SLOT_STYLE_EN], seen_reg[SLOT_STYLE_ANY],
                          off_reg[SLOT_STYLE_EN], len_reg[SLOT_STYLE_EN],
                          off_reg[SLOT_STYLE_ANY], len_reg[SLOT_STYLE_ANY], slen_reg);
        lk_fail  = (lk_fam.code != LK_OK) ? lk_fam : lk_style;

        out_next.status        = end_status_reg;
        out_next.first_offset  = '0;
        out_next.first_length  = '0;
        out_next.second_offset = '0;
        out_next.second_length = '0;
        if (end_ok_reg)
        begin
            priority if (lk_full.code == LK_OK)
            begin
                out_next.status       = ST_FULL;
                out_next.first_offset = lk_full.offset;
                out_next.first_length = lk_full.length;
            end
            else if (lk_fam.code == LK_OK && lk_style.code == LK_OK)
            begin
                out_next.status        = ST_PAIR;
                out_next.first_offset  = lk_fam.offset;
                out_next.first_length  = lk_fam.length;
                out_next.second_offset = lk_style.offset;
                out_next.second_length = lk_style.length;
            end
            else
            begin
                out_next.status = (lk_fail.code == LK_RANGE) ? ST_RANGE : ST_NOT_FOUND;
            end
        end
    end

    // Evaluation slot and output register handshake
    always_comb
    begin
        eval_valid_next = eval_valid_reg;
        out_valid_next  = out_valid_reg;
        if (result_valid && result_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (fire)
        begin
            eval_valid_next = 1'b0;
            out_valid_next  = 1'b1;
        end
        if (pop && head_cmd.end_valid)
        begin
            eval_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= '0;
            eval_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            seen_reg       <= seen_next;
            eval_valid_reg <= eval_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (keep_en)
        begin
            off_reg[en_slot] <= head_cmd.rec_offset;
            len_reg[en_slot] <= head_cmd.rec_length;
        end
        if (keep_any)
        begin
            off_reg[any_slot] <= head_cmd.rec_offset;
            len_reg[any_slot] <= head_cmd.rec_length;
        end
        if (pop && head_cmd.end_valid)
        begin
            end_ok_reg     <= head_cmd.end_ok;
            end_status_reg <= head_cmd.end_status;
            slen_reg       <= head_cmd.end_slen;
        end
        if (fire)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_hold_during_eval: assert property (@(posedge clk) disable iff (!rst_n)
        eval_valid_reg |-> !pop)
        else $error("queue popped while a table end is being resolved");

    a_clear_after_resolve: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (seen_reg == '0))
        else $error("slot valid bits not cleared after a table resolved");

endmodule
